>>> hw/rtl/akd_pkg.sv
`timescale 1ns / 1ps
// akd_pkg: shared types, codes and lookup functions for the ansi key decoder
// used by akd_decode and ansi_key_sequence_decoder_core, no dependencies
package akd_pkg;

	localparam int FUNC_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int KEY_W   = 6;
	localparam int CP_W    = 21;
	localparam int LEN_W   = 3;
	localparam int BYTES_W = 32;
	localparam int PHASE_W = 4;
	localparam int DIGIT_W = 3;
	localparam int MOD_W   = 2;

	// event kinds
	localparam logic [FUNC_W-1:0] FUNC_BYTE    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_EOF     = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

	// parser phases
	localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
	localparam logic [PHASE_W-1:0] PH_ESC       = 4'd1;
	localparam logic [PHASE_W-1:0] PH_CSI       = 4'd2;
	localparam logic [PHASE_W-1:0] PH_CSI1      = 4'd3;
	localparam logic [PHASE_W-1:0] PH_CSI1_SEMI = 4'd4;
	localparam logic [PHASE_W-1:0] PH_CSI1_MOD  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_CSI_NUM   = 4'd6;
	localparam logic [PHASE_W-1:0] PH_ABSORB    = 4'd7;
	localparam logic [PHASE_W-1:0] PH_SS3       = 4'd8;
	localparam logic [PHASE_W-1:0] PH_UTF8      = 4'd9;

	// modifiers
	localparam logic [MOD_W-1:0] MOD_NONE  = 2'd0;
	localparam logic [MOD_W-1:0] MOD_SHIFT = 2'd1;
	localparam logic [MOD_W-1:0] MOD_CTRL  = 2'd2;

	// key codes
	localparam logic [KEY_W-1:0] KEY_NONE    = 6'd0;
	localparam logic [KEY_W-1:0] KEY_CHAR    = 6'd1;
	localparam logic [KEY_W-1:0] KEY_ENTER   = 6'd2;
	localparam logic [KEY_W-1:0] KEY_BKSP    = 6'd3;
	localparam logic [KEY_W-1:0] KEY_DEL     = 6'd4;
	localparam logic [KEY_W-1:0] KEY_LEFT    = 6'd5;
	localparam logic [KEY_W-1:0] KEY_RIGHT   = 6'd6;
	localparam logic [KEY_W-1:0] KEY_UP      = 6'd7;
	localparam logic [KEY_W-1:0] KEY_DOWN    = 6'd8;
	localparam logic [KEY_W-1:0] KEY_HOME    = 6'd9;
	localparam logic [KEY_W-1:0] KEY_END     = 6'd10;
	localparam logic [KEY_W-1:0] KEY_PGUP    = 6'd11;
	localparam logic [KEY_W-1:0] KEY_PGDN    = 6'd12;
	localparam logic [KEY_W-1:0] KEY_SLEFT   = 6'd13;
	localparam logic [KEY_W-1:0] KEY_SRIGHT  = 6'd14;
	localparam logic [KEY_W-1:0] KEY_CLEFT   = 6'd15;
	localparam logic [KEY_W-1:0] KEY_CRIGHT  = 6'd16;
	localparam logic [KEY_W-1:0] KEY_CTRL_A  = 6'd17;
	localparam logic [KEY_W-1:0] KEY_CTRL_B  = 6'd18;
	localparam logic [KEY_W-1:0] KEY_CTRL_C  = 6'd19;
	localparam logic [KEY_W-1:0] KEY_CTRL_D  = 6'd20;
	localparam logic [KEY_W-1:0] KEY_CTRL_E  = 6'd21;
	localparam logic [KEY_W-1:0] KEY_CTRL_F  = 6'd22;
	localparam logic [KEY_W-1:0] KEY_CTRL_K  = 6'd23;
	localparam logic [KEY_W-1:0] KEY_CTRL_L  = 6'd24;
	localparam logic [KEY_W-1:0] KEY_CTRL_N  = 6'd25;
	localparam logic [KEY_W-1:0] KEY_CTRL_P  = 6'd26;
	localparam logic [KEY_W-1:0] KEY_CTRL_R  = 6'd27;
	localparam logic [KEY_W-1:0] KEY_CTRL_T  = 6'd28;
	localparam logic [KEY_W-1:0] KEY_CTRL_U  = 6'd29;
	localparam logic [KEY_W-1:0] KEY_CTRL_W  = 6'd30;
	localparam logic [KEY_W-1:0] KEY_CTRL_Y  = 6'd31;
	localparam logic [KEY_W-1:0] KEY_TAB     = 6'd32;
	localparam logic [KEY_W-1:0] KEY_ESC     = 6'd33;
	localparam logic [KEY_W-1:0] KEY_EOF     = 6'd34;

	// bytes of interest
	localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
	localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
	localparam logic [BYTE_W-1:0] CH_TWO   = 8'h32;
	localparam logic [BYTE_W-1:0] CH_FIVE  = 8'h35;
	localparam logic [BYTE_W-1:0] CH_SIX   = 8'h36;
	localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
	localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
	localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
	localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
	localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
	localparam logic [BYTE_W-1:0] CH_H     = 8'h48;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [DIGIT_W-1:0] digit;
		logic [MOD_W-1:0]   modifier;
		logic [BYTES_W-1:0] gathered;
		logic [LEN_W-1:0]   seq_len;
		logic [LEN_W-1:0]   count;
	} akd_state_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key_code;
		logic [CP_W-1:0]    codepoint;
		logic [LEN_W-1:0]   char_len;
		logic [BYTES_W-1:0] char_bytes;
	} akd_result_t;

	localparam akd_state_t STATE_RESET = '{
		phase: PH_IDLE, digit: '0, modifier: MOD_NONE,
		gathered: '0, seq_len: '0, count: '0};

	function automatic logic [KEY_W-1:0] final_key(input logic [BYTE_W-1:0] c);
		logic [KEY_W-1:0] k;
		case (c)
			CH_A:    k = KEY_UP;
			CH_B:    k = KEY_DOWN;
			CH_C:    k = KEY_RIGHT;
			CH_D:    k = KEY_LEFT;
			CH_H:    k = KEY_HOME;
			CH_F:    k = KEY_END;
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] control_key(input logic [BYTE_W-1:0] c);
		logic [KEY_W-1:0] k;
		case (c)
			8'h0D, 8'h0A: k = KEY_ENTER;
			8'h7F, 8'h08: k = KEY_BKSP;
			8'h09:        k = KEY_TAB;
			8'h01:        k = KEY_CTRL_A;
			8'h02:        k = KEY_CTRL_B;
			8'h03:        k = KEY_CTRL_C;
			8'h04:        k = KEY_CTRL_D;
			8'h05:        k = KEY_CTRL_E;
			8'h06:        k = KEY_CTRL_F;
			8'h0B:        k = KEY_CTRL_K;
			8'h0C:        k = KEY_CTRL_L;
			8'h0E:        k = KEY_CTRL_N;
			8'h10:        k = KEY_CTRL_P;
			8'h12:        k = KEY_CTRL_R;
			8'h14:        k = KEY_CTRL_T;
			8'h15:        k = KEY_CTRL_U;
			8'h17:        k = KEY_CTRL_W;
			8'h19:        k = KEY_CTRL_Y;
			default:      k = KEY_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [LEN_W-1:0] seq_len_of(input logic [BYTE_W-1:0] c);
		logic [LEN_W-1:0] n;
		if (c[7] == 1'b0)
			n = 3'd1;
		else if ((c & 8'hE0) == 8'hC0)
			n = 3'd2;
		else if ((c & 8'hF0) == 8'hE0)
			n = 3'd3;
		else if ((c & 8'hF8) == 8'hF0)
			n = 3'd4;
		else
			n = 3'd1;
		return n;
	endfunction

	function automatic logic [CP_W-1:0] decode_cp(input logic [BYTES_W-1:0] bytes,
		input logic [LEN_W-1:0] len);
		logic [7:0]    b0;
		logic [5:0]    b1;
		logic [5:0]    b2;
		logic [5:0]    b3;
		logic [CP_W-1:0] cp;
		b0 = bytes[7:0];
		b1 = bytes[13:8];
		b2 = bytes[21:16];
		b3 = bytes[29:24];
		case (len)
			3'd2:    cp = {10'd0, b0[4:0], b1};
			3'd3:    cp = {5'd0, b0[3:0], b1, b2};
			3'd4:    cp = {b0[2:0], b1, b2, b3};
			default: cp = {13'd0, b0};
		endcase
		return cp;
	endfunction

endpackage

>>> hw/rtl/akd_decode.sv
`timescale 1ns / 1ps
// akd_decode: next-state and result logic for one terminal input event
// depends on akd_pkg
module akd_decode (
	input  akd_pkg::akd_state_t          state_q,
	input  logic [akd_pkg::FUNC_W-1:0]   func,
	input  logic [akd_pkg::BYTE_W-1:0]   byte_in,
	output akd_pkg::akd_state_t          state_d,
	output logic                         emit,
	output akd_pkg::akd_result_t         result
);
	import akd_pkg::*;

	logic              no_byte;
	logic              is_letter;
	logic [KEY_W-1:0]  ctl_k;
	logic [KEY_W-1:0]  fin_k;
	logic [LEN_W-1:0]  first_len;
	logic [BYTES_W-1:0] merged;
	logic [LEN_W-1:0]  count_inc;

	assign no_byte   = (func != FUNC_BYTE);
	assign is_letter = (byte_in inside {[8'h41:8'h5A], [8'h61:8'h7A]});
	assign ctl_k     = control_key(byte_in);
	assign fin_k     = no_byte ? KEY_NONE : final_key(byte_in);
	assign first_len = seq_len_of(byte_in);
	assign count_inc = state_q.count + 3'd1;

	// place the new continuation byte at the gathered position
	always_comb begin
		merged = state_q.gathered;
		case (state_q.count)
			3'd1:    merged[15:8]  = byte_in;
			3'd2:    merged[23:16] = byte_in;
			3'd3:    merged[31:24] = byte_in;
			default: merged[7:0]   = state_q.gathered[7:0] | byte_in;
		endcase
	end

	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		result  = '{key_code: KEY_NONE, codepoint: '0, char_len: '0, char_bytes: '0};
		if (func != FUNC_NONE) begin
			case (state_q.phase)
				PH_IDLE: begin
					if (func == FUNC_EOF) begin
						emit = 1'b1;
						result.key_code = KEY_EOF;
					end else if (func == FUNC_BYTE) begin
						if (byte_in == CH_ESC) begin
							state_d.phase = PH_ESC;
						end else if (ctl_k != KEY_NONE) begin
							emit = 1'b1;
							result.key_code = ctl_k;
						end else if (first_len == 3'd1) begin
							emit = 1'b1;
							result.key_code   = KEY_CHAR;
							result.codepoint  = {13'd0, byte_in};
							result.char_len   = 3'd1;
							result.char_bytes = {24'd0, byte_in};
						end else begin
							state_d.phase    = PH_UTF8;
							state_d.gathered = {24'd0, byte_in};
							state_d.seq_len  = first_len;
							state_d.count    = 3'd1;
						end
					end
				end
				PH_UTF8: begin
					if (func == FUNC_EOF) begin
						emit = 1'b1;
						state_d = STATE_RESET;
						result.key_code   = KEY_CHAR;
						result.codepoint  = decode_cp(state_q.gathered, state_q.seq_len);
						result.char_len   = state_q.seq_len;
						result.char_bytes = state_q.gathered;
					end else if (func == FUNC_BYTE) begin
						if (count_inc >= state_q.seq_len) begin
							emit = 1'b1;
							state_d = STATE_RESET;
							result.key_code   = KEY_CHAR;
							result.codepoint  = decode_cp(merged, state_q.seq_len);
							result.char_len   = state_q.seq_len;
							result.char_bytes = merged;
						end else begin
							state_d.gathered = merged;
							state_d.count    = count_inc;
						end
					end
				end
				PH_ESC: begin
					if (!no_byte && byte_in == CH_LBRK) begin
						state_d.phase = PH_CSI;
					end else if (!no_byte && byte_in == CH_O) begin
						state_d.phase = PH_SS3;
					end else begin
						emit = 1'b1;
						state_d = STATE_RESET;
						result.key_code = KEY_ESC;
					end
				end
				PH_CSI: begin
					if (no_byte) begin
						emit = 1'b1;
						state_d = STATE_RESET;
						result.key_code = KEY_ESC;
					end else if (fin_k != KEY_NONE) begin
						emit = 1'b1;
						state_d = STATE_RESET;
						result.key_code = fin_k;
					end else if (byte_in == CH_ONE) begin
						state_d.phase = PH_CSI1;
					end else if (byte_in >= CH_TWO && byte_in <= CH_SIX) begin
						state_d.phase = PH_CSI_NUM;
						state_d.digit = byte_in[DIGIT_W-1:0];
					end else begin
						state_d.phase = PH_ABSORB;
					end
				end
				PH_CSI1: begin
					if (!no_byte && byte_in == CH_SEMI) begin
						state_d.phase = PH_CSI1_SEMI;
					end else begin
						emit = 1'b1;
						state_d = STATE_RESET;
						result.key_code = (!no_byte && byte_in == CH_TILDE) ? KEY_HOME : KEY_NONE;
					end
				end
				PH_CSI1_SEMI: begin
					state_d.phase = PH_CSI1_MOD;
					if (!no_byte && byte_in == CH_TWO)
						state_d.modifier = MOD_SHIFT;
					else if (!no_byte && byte_in == CH_FIVE)
						state_d.modifier = MOD_CTRL;
					else
						state_d.modifier = MOD_NONE;
				end
				PH_CSI1_MOD: begin
					emit = 1'b1;
					state_d = STATE_RESET;
					if (!no_byte && state_q.modifier == MOD_SHIFT) begin
						case (byte_in)
							CH_D:    result.key_code = KEY_SLEFT;
							CH_C:    result.key_code = KEY_SRIGHT;
							CH_A:    result.key_code = KEY_UP;
							CH_B:    result.key_code = KEY_DOWN;
							default: result.key_code = KEY_NONE;
						endcase
					end else if (!no_byte && state_q.modifier == MOD_CTRL) begin
						case (byte_in)
							CH_D:    result.key_code = KEY_CLEFT;
							CH_C:    result.key_code = KEY_CRIGHT;
							default: result.key_code = KEY_NONE;
						endcase
					end
				end
				PH_CSI_NUM: begin
					if (!no_byte && byte_in == CH_TILDE && state_q.digit >= 3'd3) begin
						emit = 1'b1;
						state_d = STATE_RESET;
						case (state_q.digit)
							3'd3:    result.key_code = KEY_DEL;
							3'd4:    result.key_code = KEY_END;
							3'd5:    result.key_code = KEY_PGUP;
							default: result.key_code = KEY_PGDN;
						endcase
					end else begin
						state_d.digit = '0;
						state_d.phase = PH_ABSORB;
					end
				end
				PH_ABSORB: begin
					if (no_byte || is_letter || byte_in == CH_TILDE) begin
						emit = 1'b1;
						state_d = STATE_RESET;
					end
				end
				PH_SS3: begin
					emit = 1'b1;
					state_d = STATE_RESET;
					result.key_code = fin_k;
				end
				default: begin
					state_d = STATE_RESET;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/ansi_key_sequence_decoder_core.sv
`timescale 1ns / 1ps
// ansi_key_sequence_decoder_core: terminal event stream to key codes and utf-8 characters
// depends on akd_pkg and akd_decode
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   in      | in_valid, in_stall   | func, byte_in
//   out     | out_valid, out_stall | key_code, codepoint, char_len, char_bytes
//
// one event per cycle unless in_stall; a key's result is registered in the output queue
// the parser state is decoded and updated in the cycle the event is taken
// results sit in a two-entry output queue; in_stall rises only when it is full
// after arst_n the parser is idle and the queue empty
module ansi_key_sequence_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [akd_pkg::FUNC_W-1:0]    func,
	input  logic [akd_pkg::BYTE_W-1:0]    byte_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [akd_pkg::KEY_W-1:0]     key_code,
	output logic [akd_pkg::CP_W-1:0]      codepoint,
	output logic [akd_pkg::LEN_W-1:0]     char_len,
	output logic [akd_pkg::BYTES_W-1:0]   char_bytes
);
	import akd_pkg::*;

	localparam logic [1:0] QUEUE_FULL = 2'd2;

	akd_state_t  state_q;
	akd_state_t  state_d;
	akd_result_t res;
	akd_result_t head_q;
	akd_result_t tail_q;
	logic        emit;
	logic [1:0]  cnt_q;
	logic        accept;
	logic        push;
	logic        pop;

	akd_decode u_decode (
		.state_q (state_q),
		.func    (func),
		.byte_in (byte_in),
		.state_d (state_d),
		.emit    (emit),
		.result  (res)
	);

	assign in_stall  = (cnt_q == QUEUE_FULL);
	assign accept    = in_valid && !in_stall;
	assign push      = accept && emit;
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;

	assign key_code   = head_q.key_code;
	assign codepoint  = head_q.codepoint;
	assign char_len   = head_q.char_len;
	assign char_bytes = head_q.char_bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			cnt_q   <= 2'd0;
		end else begin
			if (accept)
				state_q <= state_d;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// output queue payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == QUEUE_FULL)
				head_q <= tail_q;
			else if (push)
				head_q <= res;
		end else if (push) begin
			if (cnt_q == 2'd0)
				head_q <= res;
			else
				tail_q <= res;
		end
	end

endmodule

>>> test/ansi_key_sequence_decoder_core_tb.sv
`timescale 1ns / 1ps
// ansi_key_sequence_decoder_core_tb: self-checking bench for the ansi key decoder core
// a behavioral decoder predicts each key; bytes, timeouts and eof events are randomized sequences
// depends on akd_pkg and ansi_key_sequence_decoder_core
module ansi_key_sequence_decoder_core_tb;
	import akd_pkg::*;

	localparam int ITEMS        = 1550;
	localparam int TAIL_ITEMS   = 150;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		logic [FUNC_W-1:0] kind;
		logic [BYTE_W-1:0] data;
	} term_event_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [FUNC_W-1:0]    func      = FUNC_BYTE;
	logic [BYTE_W-1:0]    byte_in   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [KEY_W-1:0]     key_code;
	logic [CP_W-1:0]      codepoint;
	logic [LEN_W-1:0]     char_len;
	logic [BYTES_W-1:0]   char_bytes;

	term_event_t  term_events[$];
	akd_result_t  expected_keys[$];
	term_event_t  next_event;
	akd_result_t  want;
	int           plan_count  = 0;
	int           sent_count  = 0;
	int           gap_left    = 0;
	int           stall_left  = 0;
	int           error_count = 0;
	int           cycle_count = 0;
	logic         tail_phase  = 1'b0;

	// decoder state
	logic [PHASE_W-1:0] dec_phase;
	logic [DIGIT_W-1:0] dec_digit;
	logic [MOD_W-1:0]   dec_mod;
	logic [BYTES_W-1:0] dec_gathered;
	logic [LEN_W-1:0]   dec_len;
	logic [LEN_W-1:0]   dec_count;

	ansi_key_sequence_decoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.byte_in    (byte_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_code   (key_code),
		.codepoint  (codepoint),
		.char_len   (char_len),
		.char_bytes (char_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [KEY_W-1:0] csi_final_key(input logic [BYTE_W-1:0] c);
		if (c == CH_A) return KEY_UP;
		if (c == CH_B) return KEY_DOWN;
		if (c == CH_C) return KEY_RIGHT;
		if (c == CH_D) return KEY_LEFT;
		if (c == CH_H) return KEY_HOME;
		if (c == CH_F) return KEY_END;
		return KEY_NONE;
	endfunction

	function automatic logic [KEY_W-1:0] ctrl_key_of(input logic [BYTE_W-1:0] c);
		case (c)
			8'h0A, 8'h0D: return KEY_ENTER;
			8'h08, 8'h7F: return KEY_BKSP;
			8'h09:        return KEY_TAB;
			8'h01:        return KEY_CTRL_A;
			8'h02:        return KEY_CTRL_B;
			8'h03:        return KEY_CTRL_C;
			8'h04:        return KEY_CTRL_D;
			8'h05:        return KEY_CTRL_E;
			8'h06:        return KEY_CTRL_F;
			8'h0B:        return KEY_CTRL_K;
			8'h0C:        return KEY_CTRL_L;
			8'h0E:        return KEY_CTRL_N;
			8'h10:        return KEY_CTRL_P;
			8'h12:        return KEY_CTRL_R;
			8'h14:        return KEY_CTRL_T;
			8'h15:        return KEY_CTRL_U;
			8'h17:        return KEY_CTRL_W;
			8'h19:        return KEY_CTRL_Y;
			default:      return KEY_NONE;
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] utf8_len(input logic [BYTE_W-1:0] c);
		casez (c)
			8'b0???????: return 3'd1;
			8'b110?????: return 3'd2;
			8'b1110????: return 3'd3;
			8'b11110???: return 3'd4;
			default:     return 3'd1;
		endcase
	endfunction

	function automatic logic [CP_W-1:0] utf8_codepoint(input logic [BYTES_W-1:0] g,
		input logic [LEN_W-1:0] n);
		logic [CP_W-1:0] v;
		v = '0;
		case (n)
			3'd2:    v = CP_W'({g[4:0], g[13:8]});
			3'd3:    v = CP_W'({g[3:0], g[13:8], g[21:16]});
			3'd4:    v = {g[2:0], g[13:8], g[21:16], g[29:24]};
			default: v = CP_W'(g[7:0]);
		endcase
		return v;
	endfunction

	task automatic parser_reset();
		dec_phase    = PH_IDLE;
		dec_digit    = '0;
		dec_mod      = MOD_NONE;
		dec_gathered = '0;
		dec_len      = '0;
		dec_count    = '0;
	endtask

	task automatic emit_key(input logic [KEY_W-1:0] k);
		expected_keys.push_back('{key_code: k, codepoint: '0, char_len: '0, char_bytes: '0});
	endtask

	task automatic close_char();
		akd_result_t r;
		r.key_code   = KEY_CHAR;
		r.codepoint  = utf8_codepoint(dec_gathered, dec_len);
		r.char_len   = dec_len;
		r.char_bytes = dec_gathered;
		expected_keys.push_back(r);
		parser_reset();
	endtask

	task automatic decode_event(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b);
		logic             has_byte;
		logic [KEY_W-1:0] k;
		has_byte = (f == FUNC_BYTE);
		k = KEY_NONE;
		if (f == FUNC_NONE)
			return;
		case (dec_phase)
			PH_IDLE: begin
				if (f == FUNC_EOF)
					emit_key(KEY_EOF);
				else if (has_byte) begin
					if (b == CH_ESC)
						dec_phase = PH_ESC;
					else if (ctrl_key_of(b) != KEY_NONE)
						emit_key(ctrl_key_of(b));
					else begin
						dec_gathered = {24'd0, b};
						dec_len      = utf8_len(b);
						dec_count    = 3'd1;
						if (dec_len == 3'd1)
							close_char();
						else
							dec_phase = PH_UTF8;
					end
				end
			end
			PH_UTF8: begin
				if (f == FUNC_EOF)
					close_char();
				else if (has_byte) begin
					if (dec_count < 3'd4)
						dec_gathered = dec_gathered | (BYTES_W'(b) << (8 * dec_count));
					dec_count = dec_count + 3'd1;
					if (dec_count >= dec_len)
						close_char();
				end
			end
			PH_ESC: begin
				if (has_byte && b == CH_LBRK)
					dec_phase = PH_CSI;
				else if (has_byte && b == CH_O)
					dec_phase = PH_SS3;
				else begin
					parser_reset();
					emit_key(KEY_ESC);
				end
			end
			PH_CSI: begin
				if (!has_byte) begin
					parser_reset();
					emit_key(KEY_ESC);
				end else if (csi_final_key(b) != KEY_NONE) begin
					k = csi_final_key(b);
					parser_reset();
					emit_key(k);
				end else if (b == CH_ONE)
					dec_phase = PH_CSI1;
				else if (b >= CH_TWO && b <= CH_SIX) begin
					dec_digit = DIGIT_W'(b - 8'h30);
					dec_phase = PH_CSI_NUM;
				end else
					dec_phase = PH_ABSORB;
			end
			PH_CSI1: begin
				if (has_byte && b == CH_SEMI)
					dec_phase = PH_CSI1_SEMI;
				else begin
					parser_reset();
					emit_key((has_byte && b == CH_TILDE) ? KEY_HOME : KEY_NONE);
				end
			end
			PH_CSI1_SEMI: begin
				if (has_byte && b == CH_TWO)
					dec_mod = MOD_SHIFT;
				else if (has_byte && b == CH_FIVE)
					dec_mod = MOD_CTRL;
				else
					dec_mod = MOD_NONE;
				dec_phase = PH_CSI1_MOD;
			end
			PH_CSI1_MOD: begin
				if (has_byte && dec_mod == MOD_SHIFT) begin
					if (b == CH_D)      k = KEY_SLEFT;
					else if (b == CH_C) k = KEY_SRIGHT;
					else if (b == CH_A) k = KEY_UP;
					else if (b == CH_B) k = KEY_DOWN;
				end else if (has_byte && dec_mod == MOD_CTRL) begin
					if (b == CH_D)      k = KEY_CLEFT;
					else if (b == CH_C) k = KEY_CRIGHT;
				end
				parser_reset();
				emit_key(k);
			end
			PH_CSI_NUM: begin
				if (has_byte && b == CH_TILDE && dec_digit >= 3'd3 && dec_digit <= 3'd6) begin
					case (dec_digit)
						3'd3:    k = KEY_DEL;
						3'd4:    k = KEY_END;
						3'd5:    k = KEY_PGUP;
						default: k = KEY_PGDN;
					endcase
					parser_reset();
					emit_key(k);
				end else begin
					dec_digit = '0;
					dec_phase = PH_ABSORB;
				end
			end
			PH_ABSORB: begin
				if (!has_byte || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z")
					|| b == CH_TILDE) begin
					parser_reset();
					emit_key(KEY_NONE);
				end
			end
			PH_SS3: begin
				k = has_byte ? csi_final_key(b) : KEY_NONE;
				parser_reset();
				emit_key(k);
			end
			default: parser_reset();
		endcase
	endtask

	task automatic add_event(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b);
		term_events.push_back('{kind: f, data: b});
		if (f != FUNC_NONE)
			plan_count++;
	endtask

	task automatic add_byte(input logic [BYTE_W-1:0] b);
		add_event(FUNC_BYTE, b);
	endtask

	task automatic add_nobyte();
		add_event(($urandom_range(0, 1) == 0) ? FUNC_TIMEOUT : FUNC_EOF,
			BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic add_any();
		if ($urandom_range(0, 3) == 0)
			add_nobyte();
		else
			add_byte(BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic add_letter();
		case ($urandom_range(0, 4))
			0:       add_byte(CH_TILDE);
			1, 2:    add_byte(BYTE_W'(8'h41 + $urandom_range(0, 25)));
			default: add_byte(BYTE_W'(8'h61 + $urandom_range(0, 25)));
		endcase
	endtask

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func     <= FUNC_BYTE;
			byte_in  <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_event(func, byte_in);
				sent_count++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (term_events.size() > 0) begin
					next_event = term_events.pop_front();
					in_valid <= 1'b1;
					func     <= next_event.kind;
					byte_in  <= next_event.data;
					if (term_events.size() > TAIL_ITEMS && (sent_count / 250) % 4 != 3
						&& $urandom_range(0, 5) == 0)
						gap_left = $urandom_range(1, 12);
				end else
					in_valid <= 1'b0;
			end
			tail_phase <= (term_events.size() <= TAIL_ITEMS);
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_keys.size() == 0) begin
					if (error_count < 10)
						$display("unexpected transfer: key %0d cp %h len %0d bytes %h",
							key_code, codepoint, char_len, char_bytes);
					error_count++;
				end else begin
					want = expected_keys.pop_front();
					if (key_code !== want.key_code || codepoint !== want.codepoint
						|| char_len !== want.char_len || char_bytes !== want.char_bytes) begin
						if (error_count < 10) begin
							$write("key mismatch: expected key %0d cp %h len %0d bytes %h,",
								want.key_code, want.codepoint, want.char_len, want.char_bytes);
							$display(" got key %0d cp %h len %0d bytes %h",
								key_code, codepoint, char_len, char_bytes);
						end
						error_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!tail_phase && (cycle_count / 600) % 4 != 2
				&& $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 11);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("ansi_key_sequence_decoder_core_tb: done, errors");
			$finish;
		end
	end

	initial begin
		string finals;
		int    n;
		logic  cut;
		logic [BYTE_W-1:0] lead;
		finals = "ABCDHF";
		parser_reset();

		// directed sequences
		add_event(FUNC_EOF, 8'hFF);
		add_event(FUNC_TIMEOUT, 8'h00);
		add_event(FUNC_NONE, 8'hA5);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(CH_ESC); add_byte(CH_LBRK); add_byte(CH_A);
		add_byte(CH_ESC); add_byte(CH_LBRK); add_byte(CH_ONE); add_byte(CH_SEMI);
		add_byte(CH_FIVE); add_byte(CH_D);
		add_byte(CH_ESC); add_byte(CH_LBRK); add_byte("3"); add_byte(CH_TILDE);
		add_byte(CH_ESC); add_byte(CH_O); add_event(FUNC_TIMEOUT, 8'h00);
		add_byte(CH_ESC); add_event(FUNC_TIMEOUT, 8'h00);
		add_byte(8'hF0); add_byte(8'h9F); add_byte(8'h98); add_byte(8'h80);
		add_byte(8'hE2); add_event(FUNC_EOF, 8'h00);

		// random sequences, mostly well formed
		while (plan_count < ITEMS) begin
			case ($urandom_range(0, 19))
				0, 1: begin
					add_byte(CH_ESC); add_byte(CH_LBRK);
					if ($urandom_range(0, 3) != 0)
						add_byte(finals[$urandom_range(0, 5)]);
					else
						add_any();
				end
				2, 3: begin
					add_byte(CH_ESC); add_byte(CH_LBRK); add_byte(CH_ONE); add_byte(CH_SEMI);
					case ($urandom_range(0, 5))
						0, 1:    add_byte(CH_TWO);
						2, 3:    add_byte(CH_FIVE);
						default: add_any();
					endcase
					if ($urandom_range(0, 3) != 0)
						add_byte(finals[$urandom_range(0, 3)]);
					else
						add_any();
				end
				4: begin
					add_byte(CH_ESC); add_byte(CH_LBRK); add_byte(CH_ONE);
					if ($urandom_range(0, 1) == 0)
						add_byte(CH_TILDE);
					else
						add_any();
				end
				5, 6: begin
					add_byte(CH_ESC); add_byte(CH_LBRK);
					if ($urandom_range(0, 3) != 0)
						add_byte(BYTE_W'(CH_TWO + $urandom_range(0, 4)));
					else
						add_byte(BYTE_W'(8'h30 + $urandom_range(0, 9)));
					if ($urandom_range(0, 3) != 0)
						add_byte(CH_TILDE);
					else
						add_any();
					if ($urandom_range(0, 2) == 0) begin
						repeat ($urandom_range(0, 2))
							add_byte(BYTE_W'(8'h30 + $urandom_range(0, 11)));
						add_letter();
					end
				end
				7: begin
					add_byte(CH_ESC); add_byte(CH_O);
					if ($urandom_range(0, 3) != 0)
						add_byte(finals[$urandom_range(0, 5)]);
					else
						add_any();
				end
				8: begin
					add_byte(CH_ESC);
					add_any();
				end
				9: begin
					add_byte(CH_ESC); add_byte(CH_LBRK);
					add_byte(BYTE_W'($urandom_range(8'h20, 8'h3F)));
					repeat ($urandom_range(0, 3))
						add_byte(BYTE_W'(8'h30 + $urandom_range(0, 11)));
					if ($urandom_range(0, 5) == 0)
						add_nobyte();
					else
						add_letter();
				end
				10, 11, 12, 13: begin
					n = $urandom_range(1, 4);
					case (n)
						1:       lead = BYTE_W'($urandom_range(8'h20, 8'h7E));
						2:       lead = BYTE_W'(8'hC0 | $urandom_range(0, 31));
						3:       lead = BYTE_W'(8'hE0 | $urandom_range(0, 15));
						default: lead = BYTE_W'(8'hF0 | $urandom_range(0, 7));
					endcase
					add_byte(lead);
					cut = 1'b0;
					for (int i = 1; i < n; i++) begin
						if (!cut) begin
							if ($urandom_range(0, 7) == 0)
								add_event(FUNC_TIMEOUT, BYTE_W'($urandom_range(0, 255)));
							if ($urandom_range(0, 9) == 0) begin
								add_event(FUNC_EOF, BYTE_W'($urandom_range(0, 255)));
								cut = 1'b1;
							end else if ($urandom_range(0, 9) == 0)
								add_byte(BYTE_W'($urandom_range(0, 255)));
							else
								add_byte(BYTE_W'(8'h80 | $urandom_range(0, 63)));
						end
					end
				end
				14, 15: begin
					if ($urandom_range(0, 7) == 0)
						add_byte(8'h7F);
					else
						add_byte(BYTE_W'($urandom_range(0, 31)));
				end
				16: repeat ($urandom_range(1, 4)) add_byte(BYTE_W'($urandom_range(0, 255)));
				17: add_event(FUNC_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
				18: add_event(FUNC_NONE, BYTE_W'($urandom_range(0, 255)));
				default: add_nobyte();
			endcase
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (term_events.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_keys.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		if (error_count == 0)
			$display("ansi_key_sequence_decoder_core_tb: done, clean");
		else
			$display("ansi_key_sequence_decoder_core_tb: done, errors");
		$finish;
	end

endmodule
